// File: hdl/pool_usage_trend_predictor_macros.svh
// assertion macros for the pool usage trend predictor
`ifndef POOL_USAGE_TREND_PREDICTOR_MACROS_SVH
`define POOL_USAGE_TREND_PREDICTOR_MACROS_SVH

// checked on every clock edge outside reset
`define PUTP_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define PUTP_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hdl/putp_pkg.sv
// shared types and constants for the pool usage trend predictor
package putp_pkg;

   localparam int HISTORY_DEPTH = 24;
   localparam int COUNT_WIDTH   = 8;

   localparam int PTR_W   = $clog2(HISTORY_DEPTH);
   localparam int STEP_W  = $clog2(HISTORY_DEPTH);
   localparam int PRED_W  = COUNT_WIDTH + 1;
   localparam int SUM_W   = 13;
   localparam int NZCNT_W = 5;
   localparam int PCT_W   = 7;
   localparam int PROD_W  = COUNT_WIDTH + PCT_W;
   localparam int TREND_W = COUNT_WIDTH + 2;

   localparam logic [PCT_W-1:0] HIGH_USE_RESET = PCT_W'(70);
   localparam logic [PCT_W-1:0] PERCENT_SCALE  = PCT_W'(100);

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] used_count;
      logic [COUNT_WIDTH-1:0] total_count;
   } req_data_type;

   typedef struct packed {
      logic [PRED_W-1:0]  predicted_usage;
      logic               high_use;
      logic               grow_request;
      logic [SUM_W-1:0]   nonzero_sum;
      logic [NZCNT_W-1:0] nonzero_count;
   } rsp_data_type;

   typedef struct packed {
      logic accept;
      logic step;
      logic load;
   } ctrl_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

// File: hdl/putp_ctrl.sv
// sequencer for the history walk and result handoff
module putp_ctrl
   import putp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ctrl_cmd_type cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               step_in    = '0;
               state_in   = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_W'(HISTORY_DEPTH - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // output register free, or emptied in this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.load || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/putp_datapath.sv
// history store, backward walk accumulators and prediction arithmetic
module putp_datapath
   import putp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   input  req_data_type      req_data,
   input  logic              csr_write_enable,
   input  logic [PCT_W-1:0]  csr_write_data,
   output rsp_data_type      rsp_data
);

   logic [COUNT_WIDTH-1:0] hist_ff [HISTORY_DEPTH];
   logic [PTR_W-1:0]       wp_ff, wp_in;
   logic [PTR_W-1:0]       pos_ff, pos_in;
   logic [PCT_W-1:0]       pct_ff;
   logic [COUNT_WIDTH-1:0] used_ff, used_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic                   high_ff, high_in;
   logic [1:0]             found_ff, found_in;
   logic [COUNT_WIDTH-1:0] recent0_ff, recent0_in;
   logic [COUNT_WIDTH-1:0] recent2_ff, recent2_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [NZCNT_W-1:0]     cnt_ff, cnt_in;
   rsp_data_type           rsp_ff, rsp_in;

   logic [COUNT_WIDTH-1:0]    entry;
   logic [PROD_W-1:0]         used_scaled;
   logic [PROD_W-1:0]         total_scaled;
   logic signed [TREND_W-1:0] r0_s, r2_s, diff_s, half_s, trend_s, cap_s, clamp_s;
   logic [PRED_W-1:0]         pred;

   // history store and configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         wp_ff  <= '0;
         pct_ff <= HIGH_USE_RESET;
      end else begin
         if (cmd.accept) begin
            hist_ff[wp_ff] <= req_data.used_count;
         end
         wp_ff <= wp_in;
         if (csr_write_enable) begin
            pct_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      used_ff    <= used_in;
      total_ff   <= total_in;
      high_ff    <= high_in;
      found_ff   <= found_in;
      recent0_ff <= recent0_in;
      recent2_ff <= recent2_in;
      sum_ff     <= sum_in;
      cnt_ff     <= cnt_in;
      rsp_ff     <= rsp_in;
   end

   assign entry        = hist_ff[pos_ff];
   assign used_scaled  = PROD_W'(req_data.used_count) * PROD_W'(PERCENT_SCALE);
   assign total_scaled = PROD_W'(req_data.total_count) * PROD_W'(pct_ff);

   always_comb begin
      wp_in      = wp_ff;
      pos_in     = pos_ff;
      used_in    = used_ff;
      total_in   = total_ff;
      high_in    = high_ff;
      found_in   = found_ff;
      recent0_in = recent0_ff;
      recent2_in = recent2_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      if (cmd.accept) begin
         wp_in      = (wp_ff == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         pos_in     = wp_ff;
         used_in    = req_data.used_count;
         total_in   = req_data.total_count;
         high_in    = (req_data.total_count != '0) && (used_scaled > total_scaled);
         found_in   = 2'd0;
         sum_in     = '0;
         cnt_in     = '0;
      end else if (cmd.step) begin
         pos_in = (pos_ff == '0) ? PTR_W'(HISTORY_DEPTH - 1) : pos_ff - 1'b1;
         if (entry != '0) begin
            sum_in = sum_ff + SUM_W'(entry);
            cnt_in = cnt_ff + 1'b1;
            if (found_ff == 2'd0) begin
               recent0_in = entry;
            end
            if (found_ff == 2'd2) begin
               recent2_in = entry;
            end
            if (found_ff != 2'd3) begin
               found_in = found_ff + 1'b1;
            end
         end
      end
   end

   // trend: newest plus half the rise of three nonzero samples, clamped to [1, 2*total]; used count if fewer
   always_comb begin
      r0_s    = signed'({2'b00, recent0_ff});
      r2_s    = signed'({2'b00, recent2_ff});
      diff_s  = r0_s - r2_s;
      half_s  = (diff_s + signed'(TREND_W'(diff_s[TREND_W-1]))) >>> 1;
      trend_s = r0_s + half_s;
      cap_s   = signed'({1'b0, total_ff, 1'b0});
      clamp_s = trend_s;
      if (clamp_s > cap_s) begin
         clamp_s = cap_s;
      end
      if (clamp_s < signed'(TREND_W'(1))) begin
         clamp_s = signed'(TREND_W'(1));
      end
      if (found_ff == 2'd3) begin
         pred = clamp_s[PRED_W-1:0];
      end else begin
         pred = PRED_W'(used_ff);
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load) begin
         rsp_in.predicted_usage = pred;
         rsp_in.high_use        = high_ff;
         rsp_in.grow_request    = high_ff && (pred > PRED_W'(total_ff));
         rsp_in.nonzero_sum     = sum_ff;
         rsp_in.nonzero_count   = cnt_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: hdl/pool_usage_trend_predictor.sv
// top level: usage sample in, trend prediction and history statistics out
// an item is walked through the history, one entry per cycle over all 24 entries, then
// loaded into the output register, and rsp_valid rises; req_stall holds off the next item
// until the result is loaded and the sequencer is idle again, longer while a result waits on rsp_stall
// reset clears the history to zero, the write pointer, the threshold to 70 and the result
// valid flag; the block is ready for an item in the first cycle after reset
module pool_usage_trend_predictor
   import putp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   // sample channel
   input  logic             req_valid,
   output logic             req_stall,
   input  req_data_type     req_data,
   // result channel
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_data_type     rsp_data,
   // threshold register
   input  logic             csr_write_enable,
   input  logic [PCT_W-1:0] csr_write_data
);

   // commands from the sequencer to the datapath
   ctrl_cmd_type cmd;

   // sequencer: idle, walk of the history, handoff to the output register
   putp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // datapath: history ring, accumulators, prediction and output register
   putp_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_data         (rsp_data)
   );

endmodule

// File: hdl/putp_checker.sv
// port-level checks for the pool usage trend predictor, bound to the top level
`include "pool_usage_trend_predictor_macros.svh"

module putp_checker
   import putp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input req_data_type req_data,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_data_type rsp_data
);

   `PUTP_ASSERT_ALWAYS(a_rst_idle, reset |=> !rsp_valid, "result valid after reset")
   `PUTP_ASSERT(a_busy, (req_valid && !req_stall) |=> req_stall, "item taken while busy")
   `PUTP_ASSERT(a_rsp_held, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)), "rsp moved")
   `PUTP_ASSERT(a_req_held, (req_valid && req_stall) |=> (req_valid && $stable(req_data)), "req moved")
   `PUTP_ASSERT(a_grow_high, (rsp_valid && !rsp_data.high_use) |-> !rsp_data.grow_request, "grow, not high")

endmodule

bind pool_usage_trend_predictor putp_checker u_checker (.*);
